FILE: hdl/i2cmbe_pkg.sv
// Shared types and constants of the tick-driven two-wire bus master.
`timescale 1ns / 1ps
`default_nettype none
package i2cmbe_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BYTE_PHASES   = 2 * BITS_PER_BYTE;
  localparam int unsigned PHASE_W       = $clog2(BYTE_PHASES + 3);
  localparam int unsigned TPP_W         = 16;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ_ACK  = 3'd4,
    CMD_READ_NACK = 3'd5
  } cmd_e;

  localparam logic [PHASE_W-1:0] PH_FIRST     = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PH_SECOND    = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PH_THIRD     = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] PH_ACK_SETUP = PHASE_W'(BYTE_PHASES);
  localparam logic [PHASE_W-1:0] PH_ACK_HIGH  = PHASE_W'(BYTE_PHASES + 1);
  localparam logic [PHASE_W-1:0] PH_ACK_HOLD  = PHASE_W'(BYTE_PHASES + 2);
  localparam logic [PHASE_W-1:0] PH_START_END = PHASE_W'(3);
  localparam logic [PHASE_W-1:0] PH_STOP_END  = PHASE_W'(2);

  typedef struct packed {
    logic                     scl_drive;
    logic                     sda_drive;
    logic                     busy_res;
    logic                     done_res;
    logic [BITS_PER_BYTE-1:0] rx_byte;
    logic                     ack_seen;
    logic                     cmd_rejected;
  } res_t;

endpackage
`default_nettype wire

FILE: hdl/i2cmbe_if.sv
// Valid/ready channel interfaces for ticks in and bus status out.
`timescale 1ns / 1ps
`default_nettype none
interface i2cmbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, output cmd, output tx_byte, output sda_in, input ready);
  modport sink (input valid, input cmd, input tx_byte, input sda_in, output ready);
endinterface

interface i2cmbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_drive;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;
  logic       cmd_rejected;

  modport source (output valid, output scl_drive, output sda_drive, output busy_res,
                  output done_res, output rx_byte, output ack_seen, output cmd_rejected,
                  input ready);
  modport sink (input valid, input scl_drive, input sda_drive, input busy_res,
                input done_res, input rx_byte, input ack_seen, input cmd_rejected,
                output ready);
endinterface
`default_nettype wire

FILE: hdl/i2cmbe_seq.sv
// Bus phase sequencer: command, phase, divider and shift state advanced once per tick.
`timescale 1ns / 1ps
`default_nettype none
module i2cmbe_seq (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   en_i,
  input  wire logic [2:0]                             cmd_i,
  input  wire logic [i2cmbe_pkg::BITS_PER_BYTE-1:0]   tx_byte_i,
  input  wire logic                                   sda_in_i,
  input  wire logic [i2cmbe_pkg::TPP_W-1:0]           tpp_i,
  output i2cmbe_pkg::res_t                            res_o
);

  i2cmbe_pkg::cmd_e                           cmd_q, cmd_d, cmd_in;
  logic [i2cmbe_pkg::PHASE_W-1:0]             phase_q, phase_d, last_ph;
  logic [i2cmbe_pkg::TPP_W-1:0]               div_q, div_d, limit;
  logic [i2cmbe_pkg::BITS_PER_BYTE-1:0]       shift_q, shift_d, rx_q, rx_d;
  logic                                       ack_q, ack_d, scl_q, scl_d, sda_q, sda_d;
  logic                                       rejected, done, last_tick, is_read;

  always_comb begin
    cmd_in   = i2cmbe_pkg::cmd_e'(cmd_i);
    cmd_d    = cmd_q;
    phase_d  = phase_q;
    div_d    = div_q;
    shift_d  = shift_q;
    ack_d    = ack_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    rx_d     = rx_q;
    rejected = 1'b0;
    done     = 1'b0;
    limit    = (tpp_i == '0) ? i2cmbe_pkg::TPP_W'(1) : tpp_i;

    if (cmd_q == i2cmbe_pkg::CMD_NONE) begin
      if (cmd_in inside {[i2cmbe_pkg::CMD_START:i2cmbe_pkg::CMD_READ_NACK]}) begin
        cmd_d   = cmd_in;
        phase_d = '0;
        div_d   = '0;
        shift_d = (cmd_in == i2cmbe_pkg::CMD_WRITE) ? tx_byte_i : '0;
      end
    end else if (cmd_in != i2cmbe_pkg::CMD_NONE) begin
      rejected = 1'b1;
    end

    is_read   = (cmd_d == i2cmbe_pkg::CMD_READ_ACK) || (cmd_d == i2cmbe_pkg::CMD_READ_NACK);
    last_tick = ({1'b0, div_d} + 17'd1) >= {1'b0, limit};
    case (cmd_d)
      i2cmbe_pkg::CMD_START: last_ph = i2cmbe_pkg::PH_START_END;
      i2cmbe_pkg::CMD_STOP:  last_ph = i2cmbe_pkg::PH_STOP_END;
      default:               last_ph = i2cmbe_pkg::PH_ACK_HOLD;
    endcase

    if (cmd_d != i2cmbe_pkg::CMD_NONE) begin
      case (cmd_d)
        i2cmbe_pkg::CMD_START: begin
          if (phase_d == i2cmbe_pkg::PH_FIRST) sda_d = 1'b1;
          else if (phase_d == i2cmbe_pkg::PH_SECOND) scl_d = 1'b1;
          else if (phase_d == i2cmbe_pkg::PH_THIRD) sda_d = 1'b0;
          else scl_d = 1'b0;
        end
        i2cmbe_pkg::CMD_STOP: begin
          if (phase_d == i2cmbe_pkg::PH_FIRST) begin
            scl_d = 1'b0;
            sda_d = 1'b0;
          end else if (phase_d == i2cmbe_pkg::PH_SECOND) begin
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b1;
          end
        end
        default: begin
          if (phase_d < i2cmbe_pkg::PH_ACK_SETUP) begin
            if (!phase_d[0]) begin
              scl_d = 1'b0;
              sda_d = is_read ? 1'b1 : shift_d[i2cmbe_pkg::BITS_PER_BYTE-1];
            end else begin
              scl_d = 1'b1;
            end
          end else if (phase_d == i2cmbe_pkg::PH_ACK_SETUP) begin
            scl_d = 1'b0;
            sda_d = (cmd_d == i2cmbe_pkg::CMD_READ_ACK) ? 1'b0 : 1'b1;
          end else if (phase_d == i2cmbe_pkg::PH_ACK_HIGH) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
      endcase

      if (last_tick) begin
        if ((cmd_d != i2cmbe_pkg::CMD_START) && (cmd_d != i2cmbe_pkg::CMD_STOP)) begin
          if ((phase_d < i2cmbe_pkg::PH_ACK_SETUP) && phase_d[0]) begin
            shift_d = {shift_d[i2cmbe_pkg::BITS_PER_BYTE-2:0], is_read & sda_in_i};
          end else if ((phase_d == i2cmbe_pkg::PH_ACK_HIGH) &&
                       (cmd_d == i2cmbe_pkg::CMD_WRITE)) begin
            ack_d = !sda_in_i;
          end
        end
        div_d = '0;
        if (phase_d >= last_ph) begin
          if (is_read) rx_d = shift_d;
          cmd_d   = i2cmbe_pkg::CMD_NONE;
          phase_d = '0;
          done    = 1'b1;
        end else begin
          phase_d = phase_d + i2cmbe_pkg::PHASE_W'(1);
        end
      end else begin
        div_d = div_d + i2cmbe_pkg::TPP_W'(1);
      end
    end

    res_o.scl_drive    = scl_d;
    res_o.sda_drive    = sda_d;
    res_o.busy_res     = (cmd_d != i2cmbe_pkg::CMD_NONE);
    res_o.done_res     = done;
    res_o.rx_byte      = rx_d;
    res_o.ack_seen     = ack_d;
    res_o.cmd_rejected = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= i2cmbe_pkg::CMD_NONE;
      phase_q <= '0;
      div_q   <= '0;
      shift_q <= '0;
      ack_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      rx_q    <= '0;
    end else if (en_i) begin
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
      div_q   <= div_d;
      shift_q <= shift_d;
      ack_q   <= ack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      rx_q    <= rx_d;
    end
  end

`ifndef SYNTH
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_q == i2cmbe_pkg::CMD_NONE) |-> (phase_q == '0) && (div_q == '0))
    else $error("idle sequencer holds a stale phase or divider");
  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= i2cmbe_pkg::PH_ACK_HOLD)
    else $error("phase index beyond the last phase");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && res_o.done_res) |=> (cmd_q == i2cmbe_pkg::CMD_NONE))
    else $error("sequencer still busy after done");
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.cmd_rejected |-> (cmd_q != i2cmbe_pkg::CMD_NONE))
    else $error("command rejected while idle");
`endif

endmodule
`default_nettype wire

FILE: hdl/i2c_master_byte_engine.sv
// Latency: a tick's result is registered and shows in the cycle after its transaction.
// Throughput: one tick per cycle unless a held result stalls the input; the result register frees as it is taken.
// Each bus phase lasts ticks_per_phase ticks, set by the phase divider.
// Reset: asynchronous, active low; sequencer lines released high, sequencer idle, no result valid.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_byte_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [i2cmbe_pkg::TPP_W-1:0] cfg_wdata_i,
  i2cmbe_in_if.sink                         in_i,
  i2cmbe_out_if.source                      out_o
);

  logic                         out_valid_q;
  logic                         accept;
  logic [i2cmbe_pkg::TPP_W-1:0] tpp_q;
  i2cmbe_pkg::res_t             res_d, res_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  i2cmbe_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (accept),
    .cmd_i     (in_i.cmd),
    .tx_byte_i (in_i.tx_byte),
    .sda_in_i  (in_i.sda_in),
    .tpp_i     (tpp_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpp_q <= i2cmbe_pkg::TPP_W'(1);
    end else if (cfg_we_i) begin
      tpp_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.scl_drive    = res_q.scl_drive;
  assign out_o.sda_drive    = res_q.sda_drive;
  assign out_o.busy_res     = res_q.busy_res;
  assign out_o.done_res     = res_q.done_res;
  assign out_o.rx_byte      = res_q.rx_byte;
  assign out_o.ack_seen     = res_q.ack_seen;
  assign out_o.cmd_rejected = res_q.cmd_rejected;

`ifndef SYNTH
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted transaction left no result");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while result register is held");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> out_valid_q && $stable(res_q))
    else $error("held result changed before it was taken");
`endif

endmodule
`default_nettype wire

FILE: dv/i2c_master_byte_engine_tb.sv
// Self-checking testbench for the tick-driven two-wire bus master byte engine.
`timescale 1ns / 1ps
module i2c_master_byte_engine_tb;
  import i2cmbe_pkg::*;

  localparam logic [2:0]       CMD_RSVD_A = 3'd6;
  localparam logic [2:0]       CMD_RSVD_B = 3'd7;
  localparam logic [TPP_W-1:0] TPP_MAX    = '1;
  localparam logic [TPP_W-1:0] TPP_ZERO   = '0;

  class bus_sequencer_model;
    logic [TPP_W-1:0]         phase_ticks = 1;
    logic [2:0]               active      = CMD_NONE;
    logic [PHASE_W-1:0]       phase       = PH_FIRST;
    logic [TPP_W-1:0]         divider     = '0;
    logic [BITS_PER_BYTE-1:0] shreg       = '0;
    logic [BITS_PER_BYTE-1:0] rx_hold     = '0;
    logic                     ack         = 1'b0;
    logic                     scl         = 1'b1;
    logic                     sda         = 1'b1;
    res_t                     expected_status[$];
    int unsigned              ticks, checked, finished, rejected, errors;

    function void set_phase_ticks(logic [TPP_W-1:0] value);
      phase_ticks = value;
    endfunction

    function bit busy();
      return active != CMD_NONE;
    endfunction

    function void note_tick(logic [2:0] cmd, logic [7:0] tx, logic sda_in);
      logic [TPP_W:0]     limit;
      logic [PHASE_W-1:0] last_phase;
      logic               rej;
      logic               done;
      limit = (phase_ticks == 0) ? (TPP_W+1)'(1) : {1'b0, phase_ticks};
      rej   = 1'b0;
      done  = 1'b0;
      ticks++;
      if (active == CMD_NONE) begin
        if (cmd >= CMD_START && cmd <= CMD_READ_NACK) begin
          active  = cmd;
          phase   = PH_FIRST;
          divider = '0;
          shreg   = (cmd == CMD_WRITE) ? tx : '0;
        end
      end else if (cmd != CMD_NONE) begin
        rej = 1'b1;
        rejected++;
      end
      if (active != CMD_NONE) begin
        last_phase = (active == CMD_START) ? PH_START_END :
                     (active == CMD_STOP)  ? PH_STOP_END  : PH_ACK_HOLD;
        case (active)
          CMD_START: begin
            case (phase)
              PH_FIRST:  sda = 1'b1;
              PH_SECOND: scl = 1'b1;
              PH_THIRD:  sda = 1'b0;
              default:   scl = 1'b0;
            endcase
          end
          CMD_STOP: begin
            case (phase)
              PH_FIRST: begin
                scl = 1'b0;
                sda = 1'b0;
              end
              PH_SECOND: scl = 1'b1;
              default:   sda = 1'b1;
            endcase
          end
          default: begin
            if (phase < PH_ACK_SETUP) begin
              if (!phase[0]) begin
                scl = 1'b0;
                sda = (active == CMD_WRITE) ? shreg[BITS_PER_BYTE-1] : 1'b1;
              end else begin
                scl = 1'b1;
              end
            end else if (phase == PH_ACK_SETUP) begin
              scl = 1'b0;
              sda = (active != CMD_READ_ACK);
            end else begin
              scl = (phase == PH_ACK_HIGH);
            end
          end
        endcase
        if ({1'b0, divider} + (TPP_W+1)'(1) >= limit) begin
          if (active != CMD_START && active != CMD_STOP) begin
            if (phase < PH_ACK_SETUP && phase[0]) begin
              shreg = (active == CMD_WRITE) ? shreg << 1 : {shreg[BITS_PER_BYTE-2:0], sda_in};
            end else if (active == CMD_WRITE && phase == PH_ACK_HIGH) begin
              ack = !sda_in;
            end
          end
          divider = '0;
          if (phase == last_phase) begin
            if (active == CMD_READ_ACK || active == CMD_READ_NACK) rx_hold = shreg;
            active = CMD_NONE;
            phase  = PH_FIRST;
            done   = 1'b1;
            finished++;
          end else begin
            phase++;
          end
        end else begin
          divider++;
        end
      end
      expected_status.push_back(res_t'{scl_drive: scl, sda_drive: sda,
                                       busy_res: active != CMD_NONE, done_res: done,
                                       rx_byte: rx_hold, ack_seen: ack, cmd_rejected: rej});
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_status(res_t got);
      res_t want;
      if (expected_status.size() == 0) begin
        $error("bus status transaction arrived with nothing pending");
        errors++;
        return;
      end
      want = expected_status.pop_front();
      checked++;
      compare_field("scl_drive", want.scl_drive, got.scl_drive);
      compare_field("sda_drive", want.sda_drive, got.sda_drive);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("done_res", want.done_res, got.done_res);
      compare_field("rx_byte", want.rx_byte, got.rx_byte);
      compare_field("ack_seen", want.ack_seen, got.ack_seen);
      compare_field("cmd_rejected", want.cmd_rejected, got.cmd_rejected);
    endfunction
  endclass

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we;
  logic [TPP_W-1:0] cfg_wdata;
  int               send_idle_pct  = 11;
  int               recv_stall_pct = 82;

  bus_sequencer_model sb = new;

  i2cmbe_in_if  in_if ();
  i2cmbe_out_if out_if ();

  i2c_master_byte_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_status(res_t'{scl_drive: out_if.scl_drive, sda_drive: out_if.sda_drive,
                             busy_res: out_if.busy_res, done_res: out_if.done_res,
                             rx_byte: out_if.rx_byte, ack_seen: out_if.ack_seen,
                             cmd_rejected: out_if.cmd_rejected});
    end
  end

  function automatic logic [2:0] idle_code();
    int unsigned pick;
    pick = $urandom_range(2);
    return (pick == 0) ? CMD_NONE : (pick == 1) ? CMD_RSVD_A : CMD_RSVD_B;
  endfunction

  // Place the wanted bit on SDA where the sequencer samples it.
  function automatic logic line_level(logic [7:0] pattern, logic ack_level);
    if (sb.busy() && sb.phase < PH_ACK_SETUP && sb.phase[0])
      return pattern[BITS_PER_BYTE-1 - (sb.phase >> 1)];
    if (sb.busy() && sb.phase == PH_ACK_HIGH) return ack_level;
    return 1'($urandom);
  endfunction

  task automatic send_tick(logic [2:0] cmd, logic [7:0] tx, logic sda_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.cmd     <= cmd;
    in_if.tx_byte <= tx;
    in_if.sda_in  <= sda_in;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_tick(cmd, tx, sda_in);
  endtask

  task automatic run_command(logic [2:0] cmd, logic [7:0] tx, logic [7:0] pattern,
                             logic ack_level, int reject_pct);
    logic [2:0] stray;
    send_tick(cmd, tx, line_level(pattern, ack_level));
    while (sb.busy()) begin
      stray = ($urandom_range(99) < reject_pct) ? 3'($urandom_range(7, 1)) : CMD_NONE;
      send_tick(stray, 8'($urandom), line_level(pattern, ack_level));
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_status.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_phase_ticks(logic [TPP_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_phase_ticks(value);
  endtask

  task automatic random_traffic(int unsigned count);
    int unsigned stop_at;
    stop_at = sb.ticks + count;
    while (sb.ticks < stop_at) begin
      if ($urandom_range(99) < 8)
        send_tick(idle_code(), 8'($urandom), 1'($urandom));
      else
        run_command(3'($urandom_range(CMD_READ_NACK, CMD_START)), 8'($urandom),
                    8'($urandom), 1'($urandom), 5);
    end
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.cmd     = CMD_NONE;
    in_if.tx_byte = '0;
    in_if.sda_in  = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tick(CMD_NONE, 8'h00, 1'b1);
    send_tick(CMD_RSVD_A, 8'hFF, 1'b0);
    send_tick(CMD_RSVD_B, 8'h3C, 1'b1);
    run_command(CMD_START, 8'h00, 8'h00, 1'b0, 0);
    run_command(CMD_WRITE, 8'hFF, 8'h00, 1'b0, 0);
    run_command(CMD_WRITE, 8'h00, 8'hFF, 1'b1, 0);
    run_command(CMD_WRITE, 8'hA5, 8'h00, 1'b0, 50);
    run_command(CMD_READ_ACK, 8'h00, 8'h5A, 1'b1, 0);
    run_command(CMD_READ_NACK, 8'hFF, 8'hFF, 1'b0, 0);
    run_command(CMD_READ_ACK, 8'h00, 8'h00, 1'b1, 30);
    run_command(CMD_STOP, 8'h00, 8'h00, 1'b0, 0);

    // Hold the engine idle at the slowest phase rate.
    write_phase_ticks(TPP_MAX);
    repeat (16) send_tick(idle_code(), 8'($urandom), 1'($urandom));

    write_phase_ticks(TPP_ZERO);
    random_traffic(250);
    write_phase_ticks(2);
    random_traffic(100);
    settle();
    random_traffic(100);

    send_idle_pct  = 82;
    recv_stall_pct = 11;
    write_phase_ticks(3);
    random_traffic(200);
    write_phase_ticks(4);
    random_traffic(150);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_phase_ticks(1);
    random_traffic(230);

    settle();
    repeat (4) @(posedge clk_i);
    $display("Drove %0d ticks at phase lengths 0 to %0d; %0d commands completed, %0d rejected.",
             sb.ticks, TPP_MAX, sb.finished, sb.rejected);
    $display("Checked %0d status transactions, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("i2c_master_byte_engine test passed");
    end else begin
      $display("i2c_master_byte_engine test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("i2c_master_byte_engine test failed");
    $finish;
  end

endmodule
